// ===== hw/rtl/cel_pkg.sv =====
// Package: shared types and constants of the caret-escaping line tail.
`default_nettype none
package cel_pkg;

    localparam int LINE_WIDTH_DEF = 72;
    localparam int COUNT_W        = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 11'd2047;
    localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 11'd1000;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_DEL    = 8'd127;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_QMARK  = 8'h3F;
    localparam logic [7:0] CTRL_LAST   = 8'd31;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_CHARS = 1'd1;

    localparam logic [1:0] STATUS_CLEAN    = 2'd0;
    localparam logic [1:0] STATUS_ALTERED  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CARET,
        ST_SETUP,
        ST_RD_A,
        ST_RD_B,
        ST_LOAD
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/caret_escape_line_tail_unit.sv =====
// Top level: caret-escaping line tail with a ring store of the current line.
// Printable or dropped byte: handled in idle; control byte or DEL: two store writes.
// Newline and end of input: read out n = min(stored count, LINE_WIDTH) characters,
// one result per pair of reads (read, read, load); one result if n = 0.
// Results are registered in the load state, which holds while the output is stalled; input stalls outside idle.
// Reset (async, active low) clears control state only; the store needs no clearing pass.
`default_nettype none
module caret_escape_line_tail_unit
    import cel_pkg::*;
#(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  end_of_input,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 first_char,
    output logic [7:0]                 second_char,
    output logic [1:0]                 chars_valid,
    output logic                       line_break_after,
    output logic                       last,
    output logic                       stream_done,
    output logic [1:0]                 exit_status
);

    localparam int AW = $clog2(LINE_WIDTH);
    localparam int CW = $clog2(LINE_WIDTH + 1);
    localparam logic [AW-1:0]      LAST_POS  = AW'(LINE_WIDTH - 1);
    localparam logic [CW-1:0]      WIDTH_N   = CW'(LINE_WIDTH);
    localparam logic [COUNT_W-1:0] WIDTH_CNT = COUNT_W'(LINE_WIDTH);

    state_t state_reg, state_next;

    logic [AW-1:0]      wp_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               skip_reg;
    logic               altered_reg;
    logic               lerr_reg;
    logic               rev_reg;
    logic [COUNT_W-1:0] max_reg;
    logic               brk_reg;
    logic               done_reg;
    logic [1:0]         status_reg;
    logic [CW-1:0]      rem_reg;
    logic [1:0]         pv_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [7:0]         char_a_reg;
    logic [7:0]         caret_char_reg;

    logic               out_valid_reg;
    logic [7:0]         first_char_reg;
    logic [7:0]         second_char_reg;
    logic [1:0]         chars_valid_reg;
    logic               line_break_reg;
    logic               last_reg;
    logic               stream_done_reg;
    logic [1:0]         exit_status_reg;

    logic               in_acc;
    logic               is_nl;
    logic               is_ctrl;
    logic               is_high;
    logic [AW-1:0]      wp_inc;
    logic [COUNT_W:0]   sum1;
    logic [COUNT_W:0]   sum2;
    logic [COUNT_W-1:0] count_p1;
    logic [COUNT_W-1:0] count_p2;
    logic [CW-1:0]      n_line;
    logic [CW:0]        fwd_sum;
    logic [CW:0]        fwd_wrap;
    logic [AW-1:0]      start_fwd;
    logic [AW-1:0]      start_rev;
    logic [AW-1:0]      rd_addr_adv;
    logic               out_free;
    logic               fin;

    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [7:0]         mem_rdata;

    assign in_acc   = in_valid && !in_stall;
    assign is_nl    = (in_byte == CHAR_NL);
    assign is_ctrl  = (in_byte inside {[8'd0:CTRL_LAST]}) || (in_byte == CHAR_DEL);
    assign is_high  = in_byte[7];
    assign wp_inc   = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
    assign sum1     = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign sum2     = {1'b0, count_reg} + (COUNT_W+1)'(2);
    assign count_p1 = sum1[COUNT_W] ? COUNT_MAX : sum1[COUNT_W-1:0];
    assign count_p2 = sum2[COUNT_W] ? COUNT_MAX : sum2[COUNT_W-1:0];
    assign n_line   = (count_reg < WIDTH_CNT) ? count_reg[CW-1:0] : WIDTH_N;
    assign fwd_sum  = {1'b0, CW'(wp_reg)} + {1'b0, WIDTH_N} - {1'b0, n_line};
    assign fwd_wrap = fwd_sum - {1'b0, WIDTH_N};
    assign start_fwd = (fwd_sum >= {1'b0, WIDTH_N}) ? fwd_wrap[AW-1:0] : fwd_sum[AW-1:0];
    assign start_rev = (wp_reg == '0) ? LAST_POS : wp_reg - 1'b1;
    assign rd_addr_adv = rev_reg ?
                         ((rd_addr_reg == '0) ? LAST_POS : rd_addr_reg - 1'b1) :
                         ((rd_addr_reg == LAST_POS) ? '0 : rd_addr_reg + 1'b1);
    assign out_free = !out_valid_reg || !out_stall;
    assign fin      = (rem_reg == '0);

    cel_ram
    #(
        .WIDTH (8),
        .DEPTH (LINE_WIDTH)
    )
    u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (end_of_input)
                    begin
                        state_next = ST_SETUP;
                    end
                    else if (!skip_reg && is_nl)
                    begin
                        state_next = ST_SETUP;
                    end
                    else if (!skip_reg && is_ctrl)
                    begin
                        state_next = ST_CARET;
                    end
                end
            end
            ST_CARET: state_next = ST_IDLE;
            ST_SETUP: state_next = ST_RD_A;
            ST_RD_A:  state_next = fin ? ST_LOAD : ST_RD_B;
            ST_RD_B:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = fin ? ST_IDLE : ST_RD_A;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // store and handshake control
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_wdata = in_byte;
        mem_re    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                mem_we   = in_acc && !end_of_input && !skip_reg && (is_nl || is_ctrl || !is_high);
                if (is_nl)
                begin
                    mem_wdata = CHAR_DOLLAR;
                end
                else if (is_ctrl)
                begin
                    mem_wdata = CHAR_CARET;
                end
            end
            ST_CARET:
            begin
                mem_we    = 1'b1;
                mem_wdata = caret_char_reg;
            end
            ST_RD_A:  mem_re = !fin;
            ST_RD_B:  mem_re = !fin;
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            count_reg     <= '0;
            skip_reg      <= 1'b0;
            altered_reg   <= 1'b0;
            lerr_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            max_reg       <= MAX_CHARS_RESET;
            brk_reg       <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= STATUS_CLEAN;
            rem_reg       <= '0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REVERSE_ORDER:  rev_reg <= cfg_data[0];
                    CFG_MAX_LINE_CHARS: max_reg <= cfg_data[COUNT_W-1:0];
                    default:            rev_reg <= rev_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (end_of_input)
                        begin
                            status_reg  <= lerr_reg ? STATUS_TOO_LONG :
                                           (altered_reg ? STATUS_ALTERED : STATUS_CLEAN);
                            brk_reg     <= 1'b0;
                            done_reg    <= 1'b1;
                            skip_reg    <= 1'b0;
                            altered_reg <= 1'b0;
                            lerr_reg    <= 1'b0;
                        end
                        else if (skip_reg)
                        begin
                            if (is_nl)
                            begin
                                skip_reg <= 1'b0;
                            end
                        end
                        else if (is_nl)
                        begin
                            wp_reg    <= wp_inc;
                            count_reg <= count_p1;
                            brk_reg   <= 1'b1;
                            done_reg  <= 1'b0;
                        end
                        else if (is_ctrl)
                        begin
                            wp_reg      <= wp_inc;
                            altered_reg <= 1'b1;
                        end
                        else if (is_high)
                        begin
                            altered_reg <= 1'b1;
                        end
                        else if (count_p1 > max_reg)
                        begin
                            lerr_reg  <= 1'b1;
                            skip_reg  <= 1'b1;
                            wp_reg    <= '0;
                            count_reg <= '0;
                        end
                        else
                        begin
                            wp_reg    <= wp_inc;
                            count_reg <= count_p1;
                        end
                    end
                end
                ST_CARET:
                begin
                    if (count_p2 > max_reg)
                    begin
                        lerr_reg  <= 1'b1;
                        skip_reg  <= 1'b1;
                        wp_reg    <= '0;
                        count_reg <= '0;
                    end
                    else
                    begin
                        wp_reg    <= wp_inc;
                        count_reg <= count_p2;
                    end
                end
                ST_SETUP:
                begin
                    rem_reg   <= n_line;
                    wp_reg    <= '0;
                    count_reg <= '0;
                end
                ST_RD_A:
                begin
                    if (!fin)
                    begin
                        rem_reg <= rem_reg - 1'b1;
                        pv_reg  <= 2'd1;
                    end
                    else
                    begin
                        pv_reg <= 2'd0;
                    end
                end
                ST_RD_B:
                begin
                    if (!fin)
                    begin
                        rem_reg <= rem_reg - 1'b1;
                        pv_reg  <= 2'd2;
                    end
                end
                default:
                begin
                    rem_reg <= rem_reg;
                end
            endcase

            if ((state_reg == ST_LOAD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_acc)
        begin
            caret_char_reg <= (in_byte == CHAR_DEL) ? CHAR_QMARK : in_byte + CTRL_OFFSET;
        end
        if (state_reg == ST_SETUP)
        begin
            rd_addr_reg <= rev_reg ? start_rev : start_fwd;
        end
        else if (mem_re)
        begin
            rd_addr_reg <= rd_addr_adv;
        end
        if (state_reg == ST_RD_B)
        begin
            char_a_reg <= mem_rdata;
        end
        if ((state_reg == ST_LOAD) && out_free)
        begin
            first_char_reg  <= (pv_reg != 2'd0) ? char_a_reg : 8'd0;
            second_char_reg <= (pv_reg == 2'd2) ? mem_rdata : 8'd0;
            chars_valid_reg <= pv_reg;
            last_reg        <= fin;
            line_break_reg  <= fin && brk_reg;
            stream_done_reg <= fin && done_reg;
            exit_status_reg <= (fin && done_reg) ? status_reg : STATUS_CLEAN;
        end
    end

    assign out_valid        = out_valid_reg;
    assign first_char       = first_char_reg;
    assign second_char      = second_char_reg;
    assign chars_valid      = chars_valid_reg;
    assign line_break_after = line_break_reg;
    assign last             = last_reg;
    assign stream_done      = stream_done_reg;
    assign exit_status      = exit_status_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cel_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 72
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cel_checker.sv =====
// Checker: port-level assertions on the line tail, bound to the top level.
`default_nettype none
module cel_checker
    import cel_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] first_char,
    input wire logic [7:0] second_char,
    input wire logic [1:0] chars_valid,
    input wire logic       line_break_after,
    input wire logic       last,
    input wire logic       stream_done,
    input wire logic [1:0] exit_status
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_char) && $stable(second_char)
            && $stable(chars_valid) && $stable(last))
        else $error("result changed while stalled");

    a_empty_is_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (chars_valid == 2'd0) |-> last && stream_done && (first_char == 8'd0)
            && (second_char == 8'd0))
        else $error("empty result outside end-of-input flush");

    a_final_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (line_break_after || stream_done) |-> last
            && !(line_break_after && stream_done))
        else $error("line break or done flag on a non-final result");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stream_done |-> (exit_status == STATUS_CLEAN) && (chars_valid != 2'd3))
        else $error("status or character count out of place");

endmodule

bind caret_escape_line_tail_unit cel_checker u_cel_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .first_char       (first_char),
    .second_char      (second_char),
    .chars_valid      (chars_valid),
    .line_break_after (line_break_after),
    .last             (last),
    .stream_done      (stream_done),
    .exit_status      (exit_status)
);
`default_nettype wire
